/* rtl/core/jbmc_pkg.sv */
// Package for the baseline JPEG marker check: marker byte codes and the
// marker class record passed from the classifier to the core.
// No dependencies.
`default_nettype none

package jbmc_pkg;

	localparam logic [7:0] MARKER_PREFIX = 8'hFF;  // also the fill byte
	localparam logic [7:0] MARKER_SOI    = 8'hD8;
	localparam logic [7:0] MARKER_SOS    = 8'hDA;
	localparam logic [7:0] MARKER_SOF0   = 8'hC0;
	localparam logic [7:0] MARKER_SOF15  = 8'hCF;
	localparam logic [7:0] MARKER_DHT    = 8'hC4;
	localparam logic [7:0] MARKER_JPG    = 8'hC8;
	localparam logic [7:0] MARKER_DAC    = 8'hCC;
	localparam logic [7:0] MARKER_RST0   = 8'hD0;
	localparam logic [7:0] MARKER_EOI    = 8'hD9;
	localparam logic [7:0] MARKER_TEM    = 8'h01;
	localparam logic [7:0] MARKER_STUFF  = 8'h00;

	localparam logic [15:0] SEG_LEN_MIN = 16'd2;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	typedef struct packed {
		logic is_prefix;   // FF
		logic is_soi;      // D8
		logic is_sos;      // DA
		logic is_frame;    // any start-of-frame marker
		logic is_sof0;     // baseline frame
		logic no_segment;  // standalone marker, no length follows
	} marker_class_t;

endpackage

`default_nettype wire

/* rtl/core/jbmc_byte_if.sv */
// Byte channel of the marker check: one file byte and its end-of-file flag.
// No dependencies.
`default_nettype none

interface jbmc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/jbmc_verdict_if.sv */
// Verdict channel of the marker check: one status bit per file.
// No dependencies.
`default_nettype none

interface jbmc_verdict_if;
	logic valid;
	logic ready;
	logic status;

	modport source (output valid, output status, input ready);
	modport sink   (input valid, input status, output ready);
endinterface

`default_nettype wire

/* rtl/core/jpeg_baseline_marker_check_core.sv */
// Baseline JPEG marker check. A verdict appears in the cycle after the
// byte that decides it (or the last byte of the file). Throughput: 1 byte per
// cycle, set by the single phase register update; a byte is taken in the cycle
// the verdict register drains, bytes stall only while a verdict waits on the sink.
// Reset (arst_n low, asynchronous) returns the parser to the first header byte
// and empties the verdict register. Depends on jbmc_pkg, jbmc_byte_if,
// jbmc_verdict_if, jbmc_marker_class.
`default_nettype none

module jpeg_baseline_marker_check_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	jbmc_byte_if.sink      bytes,
	jbmc_verdict_if.source verdict
);
	import jbmc_pkg::*;

	// Parser phase. DONE swallows bytes after a verdict until end of file.
	typedef enum logic [2:0] {
		PH_HDR0,  // expect FF
		PH_HDR1,  // expect D8
		PH_SCAN,  // hunt for FF
		PH_FILL,  // after FF: fill bytes or marker code
		PH_LENH,  // segment length, high byte
		PH_LENL,  // segment length, low byte
		PH_SKIP,  // segment body
		PH_DONE
	} phase_t;

	phase_t      phase_q;
	logic [7:0]  len_high_q;
	logic [15:0] skip_q;
	logic        out_valid_q;
	logic        status_q;

	marker_class_t cls;

	phase_t      phase_n;
	logic [7:0]  len_high_n;
	logic [15:0] skip_n;
	logic        decide;      // this byte settles the verdict
	logic        decide_val;
	logic        emit;        // a verdict transfer is produced
	logic        emit_val;
	logic        accept;
	logic [15:0] seg_len;

	jbmc_marker_class u_class (
		.data_byte (bytes.data_byte),
		.cls       (cls)
	);

	// A new byte is taken whenever the verdict register is empty or drains now.
	assign bytes.ready   = !out_valid_q || verdict.ready;
	assign accept        = bytes.valid && bytes.ready;
	assign verdict.valid = out_valid_q;
	assign verdict.status = status_q;

	assign seg_len = {len_high_q, bytes.data_byte};

	// Next state for one byte.
	always_comb begin
		phase_n    = phase_q;
		len_high_n = len_high_q;
		skip_n     = skip_q;
		decide     = 1'b0;
		decide_val = STATUS_FAIL;
		case (phase_q)
			PH_HDR0: begin
				if (cls.is_prefix) begin
					phase_n = PH_HDR1;
				end else begin
					phase_n = PH_DONE;
					decide  = 1'b1;
				end
			end
			PH_HDR1: begin
				if (cls.is_soi) begin
					phase_n = PH_SCAN;
				end else begin
					phase_n = PH_DONE;
					decide  = 1'b1;
				end
			end
			PH_SCAN: begin
				if (cls.is_prefix) begin
					phase_n = PH_FILL;
				end
			end
			PH_FILL: begin
				if (cls.is_prefix) begin
					phase_n = PH_FILL;
				end else if (cls.is_sos) begin
					phase_n = PH_DONE;
					decide  = 1'b1;
				end else if (cls.is_frame) begin
					// only SOF0 counts as baseline
					phase_n    = PH_DONE;
					decide     = 1'b1;
					decide_val = cls.is_sof0 ? STATUS_OK : STATUS_FAIL;
				end else if (cls.no_segment) begin
					phase_n = PH_SCAN;
				end else begin
					phase_n = PH_LENH;
				end
			end
			PH_LENH: begin
				len_high_n = bytes.data_byte;
				phase_n    = PH_LENL;
			end
			PH_LENL: begin
				// length counts its own two bytes
				if (seg_len < SEG_LEN_MIN) begin
					phase_n = PH_DONE;
					decide  = 1'b1;
				end else begin
					skip_n  = seg_len - SEG_LEN_MIN;
					phase_n = (seg_len == SEG_LEN_MIN) ? PH_SCAN : PH_SKIP;
				end
			end
			PH_SKIP: begin
				skip_n = skip_q - 16'd1;
				if (skip_q == 16'd1) begin
					phase_n = PH_SCAN;
				end
			end
			PH_DONE: begin
				phase_n = PH_DONE;
			end
			default: begin
				phase_n = PH_DONE;
			end
		endcase

		// End of file without a verdict fails; a file already decided stays quiet.
		emit     = decide || (bytes.last_byte && (phase_q != PH_DONE));
		emit_val = decide ? decide_val : STATUS_FAIL;

		// Next file starts fresh.
		if (bytes.last_byte) begin
			phase_n    = PH_HDR0;
			len_high_n = 8'd0;
			skip_n     = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR0;
			len_high_q  <= 8'd0;
			skip_q      <= 16'd0;
			out_valid_q <= 1'b0;
			status_q    <= STATUS_FAIL;
		end else begin
			if (verdict.valid && verdict.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				phase_q    <= phase_n;
				len_high_q <= len_high_n;
				skip_q     <= skip_n;
				if (emit) begin
					out_valid_q <= 1'b1;
					status_q    <= emit_val;
				end
			end
		end
	end

`ifndef ASSERT_OFF
	// The body counter never sits at zero while skipping.
	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP) |-> (skip_q != 16'd0))
		else $error("skip phase with zero count");

	// The byte marked last always rearms the header check.
	a_last_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && bytes.last_byte) |=> (phase_q == PH_HDR0))
		else $error("last byte did not restart the parser");

	// A produced verdict lands in the output register with its value.
	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit) |=> (out_valid_q && (status_q == $past(emit_val))))
		else $error("verdict lost");

	// An OK verdict only follows a baseline SOF0 marker byte.
	a_ok_from_sof0: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit && (emit_val == STATUS_OK)) |-> (phase_q == PH_FILL && cls.is_sof0))
		else $error("OK verdict without SOF0");
`endif

endmodule

`default_nettype wire

/* rtl/core/jbmc_marker_class.sv */
// Marker byte classifier for the baseline JPEG marker check.
// Depends on jbmc_pkg.
`default_nettype none

module jbmc_marker_class (
	input  wire logic [7:0]            data_byte,
	output jbmc_pkg::marker_class_t    cls
);
	import jbmc_pkg::*;

	always_comb begin
		cls.is_prefix  = (data_byte == MARKER_PREFIX);
		cls.is_soi     = (data_byte == MARKER_SOI);
		cls.is_sos     = (data_byte == MARKER_SOS);
		cls.is_sof0    = (data_byte == MARKER_SOF0);
		// C0..CF minus DHT, JPG and DAC
		cls.is_frame   = (data_byte inside {[MARKER_SOF0:MARKER_SOF15]})
			&& (data_byte != MARKER_DHT) && (data_byte != MARKER_JPG)
			&& (data_byte != MARKER_DAC);
		cls.no_segment = (data_byte == MARKER_STUFF) || (data_byte == MARKER_TEM)
			|| (data_byte inside {[MARKER_RST0:MARKER_EOI]});
	end

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench for jpeg_baseline_marker_check_core: streams JPEG-like files byte by byte
// and checks each verdict against a cycle-free predictor of the marker parser.
// Depends on jbmc_pkg, jbmc_byte_if, jbmc_verdict_if and the core itself.

module tb;
	import jbmc_pkg::*;

	localparam int CLK_HALF    = 10;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int RAND_BYTES  = 650;   // per idle setting, three settings

	typedef enum logic [2:0] {
		PH_HDR0, PH_HDR1, PH_SCAN, PH_FILL, PH_LENH, PH_LENL, PH_SKIP, PH_DONE
	} parse_phase_t;

	logic clk;
	logic arst_n;

	jbmc_byte_if    byte_ch ();
	jbmc_verdict_if verdict_ch ();

	jpeg_baseline_marker_check_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (byte_ch),
		.verdict (verdict_ch)
	);

	// predictor state, mirrors the parser
	parse_phase_t parse_phase;
	logic [7:0]   len_hi;
	logic [15:0]  skip_left;

	logic       verdicts_due[$];   // predicted status per file, oldest first
	logic [7:0] file_bytes[$];     // file being sent
	logic       due_status;
	logic       hold_verdicts;
	int         src_idle_pct;
	int         snk_idle_pct;
	int         bytes_sent;
	int         errors;
	int         cycles;

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	// ------------------------------------------------------------------
	// Marker classes
	// ------------------------------------------------------------------
	function automatic logic frame_marker(input logic [7:0] m);
		if (m < MARKER_SOF0 || m > MARKER_SOF15)
			return 1'b0;
		return m != MARKER_DHT && m != MARKER_JPG && m != MARKER_DAC;
	endfunction

	function automatic logic standalone_marker(input logic [7:0] m);
		return m == MARKER_STUFF || m == MARKER_TEM || (m >= MARKER_RST0 && m <= MARKER_EOI);
	endfunction

	// ------------------------------------------------------------------
	// Predictor: one accepted byte in, zero or one status queued
	// ------------------------------------------------------------------
	function automatic void predict_verdict(input logic [7:0] b, input logic eof);
		logic [15:0] seg_len;
		logic        decided;
		logic        st;
		logic        was_done;
		decided  = 1'b0;
		st       = STATUS_FAIL;
		was_done = (parse_phase == PH_DONE);
		case (parse_phase)
			PH_HDR0: begin
				if (b != MARKER_PREFIX) begin
					decided     = 1'b1;
					parse_phase = PH_DONE;
				end else
					parse_phase = PH_HDR1;
			end
			PH_HDR1: begin
				if (b != MARKER_SOI) begin
					decided     = 1'b1;
					parse_phase = PH_DONE;
				end else
					parse_phase = PH_SCAN;
			end
			PH_SCAN: begin
				if (b == MARKER_PREFIX)
					parse_phase = PH_FILL;
			end
			PH_FILL: begin
				if (b == MARKER_PREFIX) begin
					// fill byte, stay
				end else if (b == MARKER_SOS) begin
					decided     = 1'b1;
					parse_phase = PH_DONE;
				end else if (frame_marker(b)) begin
					decided     = 1'b1;
					st          = (b == MARKER_SOF0) ? STATUS_OK : STATUS_FAIL;
					parse_phase = PH_DONE;
				end else if (standalone_marker(b))
					parse_phase = PH_SCAN;
				else
					parse_phase = PH_LENH;
			end
			PH_LENH: begin
				len_hi      = b;
				parse_phase = PH_LENL;
			end
			PH_LENL: begin
				seg_len = {len_hi, b};
				if (seg_len < SEG_LEN_MIN) begin
					decided     = 1'b1;
					parse_phase = PH_DONE;
				end else begin
					skip_left   = seg_len - SEG_LEN_MIN;
					parse_phase = (skip_left == 16'd0) ? PH_SCAN : PH_SKIP;
				end
			end
			PH_SKIP: begin
				skip_left = skip_left - 16'd1;
				if (skip_left == 16'd0)
					parse_phase = PH_SCAN;
			end
			default: ;
		endcase
		// file ended with no verdict yet
		if (!decided && eof && !was_done)
			decided = 1'b1;
		if (decided)
			verdicts_due.push_back(st);
		if (eof) begin
			parse_phase = PH_HDR0;
			len_hi      = 8'd0;
			skip_left   = 16'd0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Byte sender and file sender
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic eof);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.last_byte <= eof;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		// transfer done at this edge
		predict_verdict(b, eof);
		bytes_sent++;
	endtask

	task automatic send_file();
		for (int i = 0; i < file_bytes.size(); i++)
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
	endtask

	// stop offering and let every predicted verdict come out
	task automatic wait_for_verdicts();
		byte_ch.valid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Random file: mostly a well-formed header and segments, some noise
	// ------------------------------------------------------------------
	function automatic void build_random_file();
		int          nseg;
		int          kind;
		int          body_n;
		int          cut;
		logic [7:0]  m;
		logic [15:0] seg_len;
		file_bytes.delete();
		if ($urandom_range(0, 99) < 15) begin
			// noise, sometimes behind a valid header
			if ($urandom_range(0, 1) == 1) begin
				file_bytes.push_back(MARKER_PREFIX);
				file_bytes.push_back(MARKER_SOI);
			end
			repeat ($urandom_range(1, 12))
				file_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		file_bytes.push_back(MARKER_PREFIX);
		file_bytes.push_back(MARKER_SOI);
		nseg = $urandom_range(0, 4);
		repeat (nseg) begin
			kind = $urandom_range(0, 9);
			if (kind < 2) begin
				// entropy-like junk between markers
				repeat ($urandom_range(1, 3))
					file_bytes.push_back(8'($urandom_range(0, 254)));
			end else if (kind < 4) begin
				file_bytes.push_back(MARKER_PREFIX);
				repeat ($urandom_range(0, 2))
					file_bytes.push_back(MARKER_PREFIX);
				case ($urandom_range(0, 2))
					0: m = MARKER_STUFF;
					1: m = MARKER_TEM;
					default: m = MARKER_RST0 + 8'($urandom_range(0, 9));
				endcase
				file_bytes.push_back(m);
			end else begin
				file_bytes.push_back(MARKER_PREFIX);
				if ($urandom_range(0, 3) == 0)
					file_bytes.push_back(MARKER_PREFIX);
				do
					m = 8'($urandom_range(0, 255));
				while (m == MARKER_PREFIX || m == MARKER_SOS || frame_marker(m)
					|| standalone_marker(m));
				file_bytes.push_back(m);
				case ($urandom_range(0, 19))
					0: seg_len = 16'($urandom_range(0, 1));        // too short
					1: seg_len = 16'($urandom_range(0, 65535));    // runs past the end
					default: seg_len = 16'($urandom_range(2, 8));
				endcase
				file_bytes.push_back(seg_len[15:8]);
				file_bytes.push_back(seg_len[7:0]);
				body_n = (seg_len < SEG_LEN_MIN) ? 0 : int'(seg_len) - 2;
				if (body_n > 16)
					body_n = 16;
				repeat (body_n)
					file_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
		kind = $urandom_range(0, 9);
		if (kind < 8) begin
			file_bytes.push_back(MARKER_PREFIX);
			if (kind < 6)
				m = MARKER_SOF0;
			else if (kind == 6) begin
				do
					m = 8'($urandom_range(MARKER_SOF0 + 1, MARKER_SOF15));
				while (!frame_marker(m));
			end else
				m = MARKER_SOS;
			file_bytes.push_back(m);
		end
		// bytes after the verdict are swallowed
		repeat ($urandom_range(0, 3))
			file_bytes.push_back(8'($urandom_range(0, 255)));
		// cut some files short
		if ($urandom_range(0, 99) < 15) begin
			cut = $urandom_range(1, file_bytes.size());
			while (file_bytes.size() > cut)
				void'(file_bytes.pop_back());
		end
	endfunction

	// ------------------------------------------------------------------
	// Test tasks
	// ------------------------------------------------------------------
	task automatic test_directed_files();
		// bad first header byte, one-byte file
		file_bytes = {8'h00};
		send_file();
		// bad second header byte
		file_bytes = {MARKER_PREFIX, 8'h00};
		send_file();
		// header only: file ends before any marker
		file_bytes = {MARKER_PREFIX, MARKER_SOI};
		send_file();
		// fill bytes before baseline frame, tail swallowed
		file_bytes = {MARKER_PREFIX, MARKER_SOI, MARKER_PREFIX, MARKER_PREFIX, MARKER_SOF0,
			8'hFF};
		send_file();
		// restart marker skipped, progressive frame decides on the last byte
		file_bytes = {MARKER_PREFIX, MARKER_SOI, MARKER_PREFIX, MARKER_RST0, MARKER_PREFIX,
			8'hC2};
		send_file();
		// segment length below minimum
		file_bytes = {MARKER_PREFIX, MARKER_SOI, MARKER_PREFIX, 8'hE0, 8'h00, 8'h01};
		send_file();
		// empty-body segment, then scan before any frame
		file_bytes = {MARKER_PREFIX, MARKER_SOI, MARKER_PREFIX, 8'hDB, 8'h00, 8'h02,
			MARKER_PREFIX, MARKER_SOS};
		send_file();
		wait_for_verdicts();
	endtask

	task automatic test_random_files(input int src_pct, input int snk_pct, input int nbytes);
		int target;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		target = bytes_sent + nbytes;
		while (bytes_sent < target) begin
			build_random_file();
			send_file();
		end
		wait_for_verdicts();
	endtask

	// verdict side held off while one-byte failing files keep coming,
	// so the verdict register fills and the byte side stalls
	task automatic test_verdict_backpressure();
		fork
			begin
				hold_verdicts <= 1'b1;
				repeat (HOLD_CYCLES)
					@(posedge clk);
				hold_verdicts <= 1'b0;
			end
			begin
				for (int k = 0; k < 40; k++) begin
					file_bytes = {8'($urandom_range(0, 254))};
					send_file();
				end
			end
		join
		wait_for_verdicts();
	endtask

	// ------------------------------------------------------------------
	// Verdict receiver and checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_verdicts)
			verdict_ch.ready <= 1'b0;
		else
			verdict_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && verdict_ch.valid && verdict_ch.ready) begin
			if (verdicts_due.size() == 0) begin
				$display("%0t: verdict with none expected, actual status %b", $time,
					verdict_ch.status);
				errors++;
			end else begin
				due_status = verdicts_due.pop_front();
				if (verdict_ch.status !== due_status) begin
					$display("%0t: status mismatch, expected %b actual %b", $time,
						due_status, verdict_ch.status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n            = 1'b0;
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = 8'd0;
		byte_ch.last_byte = 1'b0;
		verdict_ch.ready  = 1'b0;
		hold_verdicts     = 1'b0;
		src_idle_pct      = 33;
		snk_idle_pct      = 74;
		bytes_sent        = 0;
		errors            = 0;
		cycles            = 0;
		parse_phase       = PH_HDR0;
		len_hi            = 8'd0;
		skip_left         = 16'd0;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;

		test_directed_files();
		test_random_files(33, 74, RAND_BYTES);
		test_verdict_backpressure();
		test_random_files(74, 33, RAND_BYTES);
		test_random_files(0, 0, RAND_BYTES);

		// nothing outstanding; give a stray verdict time to show up
		repeat (8)
			@(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
